// ===== hdl/odo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package odo_pkg;

  localparam int unsigned CFG_IW    = 3;
  localparam int unsigned ZW        = 34;
  localparam int unsigned XW        = 34;
  localparam int unsigned CW        = XW - 14;
  localparam int unsigned ATAN_LEN  = 24;

  // gain-compensated 1.0 in Q2.30
  localparam logic [31:0] CORDIC_X0 = 32'd652032874;

  localparam logic [CFG_IW-1:0] REG_DIST_PER_COUNT = 3'd0;
  localparam logic [CFG_IW-1:0] REG_TURN_PER_COUNT = 3'd1;
  localparam logic [CFG_IW-1:0] REG_START_X        = 3'd2;
  localparam logic [CFG_IW-1:0] REG_START_Y        = 3'd3;
  localparam logic [CFG_IW-1:0] REG_START_HEADING  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_SCALE,
    ST_CORDIC,
    ST_TRIG,
    ST_PROJ,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic calc_delta;
    logic scale;
    logic cordic_step;
    logic trig;
    logic project;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic cordic_last;
    logic out_free;
  } status_t;

  // atan(2^-i) in binary angle units, full turn = 2^32
  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/odo_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module odo_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic             s_tuser,
  output logic                  s_tready,
  input  wire odo_pkg::status_t status,
  output odo_pkg::cmd_t         cmd
);

  odo_pkg::state_t state;
  odo_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= odo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      odo_pkg::ST_IDLE: begin
        s_tready   = !rst;
        cmd.accept = s_tvalid && !rst;
        if (cmd.accept) begin
          // restart skips all motion math
          state_next = s_tuser ? odo_pkg::ST_COMMIT : odo_pkg::ST_DELTA;
        end
      end
      odo_pkg::ST_DELTA: begin
        cmd.calc_delta = 1'b1;
        state_next     = odo_pkg::ST_SCALE;
      end
      odo_pkg::ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = odo_pkg::ST_CORDIC;
      end
      odo_pkg::ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (status.cordic_last) begin
          state_next = odo_pkg::ST_TRIG;
        end
      end
      odo_pkg::ST_TRIG: begin
        cmd.trig   = 1'b1;
        state_next = odo_pkg::ST_PROJ;
      end
      odo_pkg::ST_PROJ: begin
        cmd.project = 1'b1;
        state_next  = odo_pkg::ST_COMMIT;
      end
      odo_pkg::ST_COMMIT: begin
        // hold until the output register can take the new pose
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = odo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = odo_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/odo_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module odo_dpath #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned DELTA_LIMIT  = 32767
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire odo_pkg::cmd_t               cmd,
  output odo_pkg::status_t                 status,
  input  wire logic [63:0]                 s_tdata,
  input  wire logic                        s_tuser,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [95:0]                      m_tdata,
  output logic                             m_tuser,
  input  wire logic                        cfg_valid,
  input  wire logic [odo_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [31:0]                 cfg_data
);

  localparam int unsigned DW  = $clog2(DELTA_LIMIT + 1) + 1;
  localparam int unsigned PW  = DW + 34;
  localparam int unsigned MW  = PW - 17;
  localparam int unsigned PDW = MW + odo_pkg::CW;
  localparam int unsigned IW  = $clog2(CORDIC_STEPS);
  localparam logic signed [31:0] LIM = 32'(DELTA_LIMIT);

  // configuration
  logic [31:0] dist_per_count;
  logic [31:0] turn_per_count;
  logic [31:0] start_x;
  logic [31:0] start_y;
  logic [31:0] start_heading;

  // pose and count baseline
  logic [31:0] last_left;
  logic [31:0] last_right;
  logic [31:0] x_acc;
  logic [31:0] y_acc;
  logic [31:0] heading_acc;

  // captured item
  logic [31:0] in_left;
  logic [31:0] in_right;
  logic        in_restart;

  logic signed [DW-1:0] dl;
  logic signed [DW-1:0] dr;
  logic                 clip;

  logic signed [PW-1:0] mean_prod;
  logic signed [PW-1:0] turn_prod;

  logic signed [odo_pkg::XW-1:0] cx;
  logic signed [odo_pkg::XW-1:0] cy;
  logic signed [odo_pkg::ZW-1:0] cz;
  logic [IW-1:0]                 iter;
  logic                          flip;

  logic signed [odo_pkg::CW-1:0] cos_v;
  logic signed [odo_pkg::CW-1:0] sin_v;
  logic signed [PDW-1:0]         pdx;
  logic signed [PDW-1:0]         pdy;

  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_heading;
  logic        out_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_count <= '0;
      turn_per_count <= '0;
      start_x        <= '0;
      start_y        <= '0;
      start_heading  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        odo_pkg::REG_DIST_PER_COUNT: dist_per_count <= cfg_data;
        odo_pkg::REG_TURN_PER_COUNT: turn_per_count <= cfg_data;
        odo_pkg::REG_START_X:        start_x        <= cfg_data;
        odo_pkg::REG_START_Y:        start_y        <= cfg_data;
        odo_pkg::REG_START_HEADING:  start_heading  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_left    <= s_tdata[31:0];
      in_right   <= s_tdata[63:32];
      in_restart <= s_tuser;
    end
  end

  // wrap the count difference to signed, then clamp
  logic signed [31:0] raw_l;
  logic signed [31:0] raw_r;
  logic signed [DW-1:0] sat_l;
  logic signed [DW-1:0] sat_r;
  logic clip_l;
  logic clip_r;

  always_comb begin
    raw_l  = $signed(in_left - last_left);
    raw_r  = $signed(in_right - last_right);
    clip_l = (raw_l > LIM) || (raw_l < -LIM);
    clip_r = (raw_r > LIM) || (raw_r < -LIM);
    if (raw_l > LIM) begin
      sat_l = DW'(LIM);
    end else if (raw_l < -LIM) begin
      sat_l = DW'(-LIM);
    end else begin
      sat_l = DW'(raw_l);
    end
    if (raw_r > LIM) begin
      sat_r = DW'(LIM);
    end else if (raw_r < -LIM) begin
      sat_r = DW'(-LIM);
    end else begin
      sat_r = DW'(raw_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_delta) begin
      dl   <= sat_l;
      dr   <= sat_r;
      clip <= clip_l | clip_r;
    end
  end

  logic signed [DW:0] d_sum;
  logic signed [DW:0] d_diff;
  assign d_sum  = (DW + 1)'(dl) + (DW + 1)'(dr);
  assign d_diff = (DW + 1)'(dl) - (DW + 1)'(dr);

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      mean_prod <= PW'(d_sum) * PW'($signed({1'b0, dist_per_count}));
      turn_prod <= PW'(d_diff) * PW'($signed({1'b0, turn_per_count}));
    end
  end

  // fold heading into [-1/4, 1/4) turn; negate the result back afterwards
  logic [31:0] fold_ang;
  assign fold_ang = {heading_acc[31] ^ (heading_acc[31] ^ heading_acc[30]), heading_acc[30:0]};

  logic signed [odo_pkg::XW-1:0] xs;
  logic signed [odo_pkg::XW-1:0] ys;
  logic signed [odo_pkg::ZW-1:0] atan_v;
  assign xs     = cx >>> iter;
  assign ys     = cy >>> iter;
  assign atan_v = odo_pkg::ZW'(odo_pkg::atan_lut(5'(iter)));

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      cx   <= odo_pkg::XW'(odo_pkg::CORDIC_X0);
      cy   <= '0;
      cz   <= odo_pkg::ZW'($signed(fold_ang));
      iter <= '0;
      flip <= heading_acc[31] ^ heading_acc[30];
    end else if (cmd.cordic_step) begin
      if (!cz[odo_pkg::ZW-1]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_v;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_v;
      end
      iter <= iter + 1'b1;
    end
  end

  assign status.cordic_last = (iter == IW'(CORDIC_STEPS - 1));

  logic signed [odo_pkg::XW-1:0] fx;
  logic signed [odo_pkg::XW-1:0] fy;
  assign fx = flip ? -cx : cx;
  assign fy = flip ? -cy : cy;

  always_ff @(posedge clk) begin
    if (cmd.trig) begin
      cos_v <= odo_pkg::CW'(fx >>> 14);
      sin_v <= odo_pkg::CW'(fy >>> 14);
    end
  end

  logic signed [MW-1:0] mean;
  assign mean = mean_prod[PW-1:17];

  always_ff @(posedge clk) begin
    if (cmd.project) begin
      pdx <= PDW'(mean) * PDW'(cos_v);
      pdy <= PDW'(mean) * PDW'(sin_v);
    end
  end

  logic signed [63:0] pdx_ext;
  logic signed [63:0] pdy_ext;
  logic signed [63:0] turn_ext;
  logic [31:0] x_new;
  logic [31:0] y_new;
  logic [31:0] heading_new;

  assign pdx_ext  = 64'(pdx);
  assign pdy_ext  = 64'(pdy);
  assign turn_ext = 64'(turn_prod);

  always_comb begin
    if (in_restart) begin
      x_new       = start_x;
      y_new       = start_y;
      heading_new = start_heading;
    end else begin
      x_new       = x_acc + pdx_ext[47:16];
      y_new       = y_acc + pdy_ext[47:16];
      heading_new = heading_acc + turn_ext[47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_left   <= '0;
      last_right  <= '0;
      x_acc       <= '0;
      y_acc       <= '0;
      heading_acc <= '0;
    end else if (cmd.commit) begin
      last_left   <= in_left;
      last_right  <= in_right;
      x_acc       <= x_new;
      y_acc       <= y_new;
      heading_acc <= heading_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_x       <= x_new;
      out_y       <= y_new;
      out_heading <= heading_new;
      out_clip    <= !in_restart && clip;
    end
  end

  assign status.out_free = !m_tvalid || m_tready;
  assign m_tdata         = {out_heading, out_y, out_x};
  assign m_tuser         = out_clip;

endmodule
`default_nettype wire

// ===== hdl/differential_drive_odometry.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Fields
// s_*       in   tdata: left_count, right_count; tuser: restart
// m_*       out  tdata: pose_x, pose_y, pose_heading; tuser: delta_clipped
// cfg_*     in   cfg_index: register number, cfg_data: value
//
// A motion tick runs through DELTA, SCALE, CORDIC, TRIG, PROJ and COMMIT; its
// length is set by the one-rotation-per-cycle CORDIC, and its pose is registered
// at COMMIT. A restart tick goes from accept straight to COMMIT.
// One tick is in flight; the output register lets the next start while a
// result waits, and a result not taken holds the tick in its last step.
// rst is synchronous, holds both readies low and clears pose, baseline, registers.
module differential_drive_odometry #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned DELTA_LIMIT  = 32767
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [63:0]                 s_tdata,   // left_count, right_count
  input  wire logic                        s_tuser,   // restart
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [95:0]                      m_tdata,   // pose_x, pose_y, pose_heading
  output logic                             m_tuser,   // delta_clipped
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [odo_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [31:0]                 cfg_data
);

  odo_pkg::cmd_t    cmd;
  odo_pkg::status_t status;

  assign cfg_ready = !rst;

  odo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  odo_dpath #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .DELTA_LIMIT  (DELTA_LIMIT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire
